/* rtl/fdp_pkg.sv */
// Shared widths and stage types for the transverse projection pipeline.
// No dependencies; imported by fourier_divergence_projection.
package fdp_pkg;

   localparam int BW   = 32;            // field word, Q16.16
   localparam int KW   = 11;            // wave index
   localparam int NL   = 6;             // field lanes: x,y,z times real,imag
   localparam int NK   = 3;             // wave components
   localparam int NP   = 2;             // real, imag
   localparam int SQW  = 2 * (KW - 1) + 1;  // one squared index, unsigned
   localparam int K2W  = SQW + 1;           // |k|^2, unsigned
   localparam int KBW  = BW + KW;           // k_i * b_i, signed
   localparam int DOTW = KBW + 2;           // k . b, signed
   localparam int NUMW = DOTW + KW;         // k_i * (k . b), signed
   localparam int QW   = BW + 1;            // quotient magnitude bits
   localparam int RW   = NUMW + 1;          // divider remainder width
   localparam int SW   = QW + 2;            // b -/+ q before clamping

   typedef logic [NL-1:0][BW-1:0] lanes_type;

   // One step of the shared-divisor restoring divider, all six lanes.
   typedef struct packed {
      lanes_type               b;
      logic [K2W-1:0]          ksq;
      logic                    zero;
      logic [NL-1:0]           neg;
      logic [NL-1:0][RW-1:0]   rem;
      logic [NL-1:0][QW-1:0]   quo;
   } div_stage_type;

endpackage

/* rtl/fourier_divergence_projection.sv */
// Removes the component along k from one complex field vector per beat.
// Throughput: one beat per cycle while no rsp beat is waiting; the 33 one-bit
// restoring-division steps set the depth.
// A waiting rsp beat holds the whole pipeline; req_ready follows rsp_ready meanwhile.
// Reset (synchronous) clears all valid bits; data registers are not reset.
// Depends on fdp_pkg.
module fourier_divergence_projection (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic signed [fdp_pkg::BW-1:0]    req_bx_real,
   input  logic signed [fdp_pkg::BW-1:0]    req_bx_imag,
   input  logic signed [fdp_pkg::BW-1:0]    req_by_real,
   input  logic signed [fdp_pkg::BW-1:0]    req_by_imag,
   input  logic signed [fdp_pkg::BW-1:0]    req_bz_real,
   input  logic signed [fdp_pkg::BW-1:0]    req_bz_imag,
   input  logic signed [fdp_pkg::KW-1:0]    req_wave_x,
   input  logic signed [fdp_pkg::KW-1:0]    req_wave_y,
   input  logic signed [fdp_pkg::KW-1:0]    req_wave_z,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic signed [fdp_pkg::BW-1:0]    rsp_px_real,
   output logic signed [fdp_pkg::BW-1:0]    rsp_px_imag,
   output logic signed [fdp_pkg::BW-1:0]    rsp_py_real,
   output logic signed [fdp_pkg::BW-1:0]    rsp_py_imag,
   output logic signed [fdp_pkg::BW-1:0]    rsp_pz_real,
   output logic signed [fdp_pkg::BW-1:0]    rsp_pz_imag
);
   import fdp_pkg::*;

   logic                    adv;
   logic signed [BW-1:0]    in_b [NL];
   logic signed [KW-1:0]    in_k [NK];

   // stage 1: squares and k_i * b_i
   logic                    s1_valid_ff;
   logic signed [BW-1:0]    s1_b_ff  [NL];
   logic signed [KW-1:0]    s1_k_ff  [NK];
   logic [SQW-1:0]          s1_sq_ff [NK];
   logic [SQW-1:0]          s1_sq_in [NK];
   logic signed [KBW-1:0]   s1_kb_ff [NL];
   logic signed [KBW-1:0]   s1_kb_in [NL];
   logic signed [2*KW-1:0]  sq_full  [NK];

   // stage 2: |k|^2 and dot products
   logic                    s2_valid_ff;
   logic signed [BW-1:0]    s2_b_ff   [NL];
   logic signed [KW-1:0]    s2_k_ff   [NK];
   logic [K2W-1:0]          s2_ksq_ff;
   logic [K2W-1:0]          s2_ksq_in;
   logic signed [DOTW-1:0]  s2_dot_ff [NP];
   logic signed [DOTW-1:0]  s2_dot_in [NP];

   // stage 3: numerators k_i * (k . b)
   logic                    s3_valid_ff;
   logic signed [BW-1:0]    s3_b_ff   [NL];
   logic [K2W-1:0]          s3_ksq_ff;
   logic signed [NUMW-1:0]  s3_num_ff [NL];
   logic signed [NUMW-1:0]  s3_num_in [NL];

   // stage 4 onward: sign/magnitude split, then one quotient bit per stage
   logic [QW:0]             dv_valid_ff;
   div_stage_type           div_ff [QW+1];
   div_stage_type           div_in [QW+1];

   // output register
   logic                    rsp_valid_ff;
   logic [BW-1:0]           rsp_p_ff [NL];
   logic [BW-1:0]           rsp_p_in [NL];

   assign adv       = !rsp_valid_ff || rsp_ready;
   assign req_ready = adv;

   assign in_b[0] = req_bx_real;
   assign in_b[1] = req_bx_imag;
   assign in_b[2] = req_by_real;
   assign in_b[3] = req_by_imag;
   assign in_b[4] = req_bz_real;
   assign in_b[5] = req_bz_imag;
   assign in_k[0] = req_wave_x;
   assign in_k[1] = req_wave_y;
   assign in_k[2] = req_wave_z;

   always_comb begin
      for (int c = 0; c < NK; c++) begin
         sq_full[c]  = in_k[c] * in_k[c];
         s1_sq_in[c] = sq_full[c][SQW-1:0];
         for (int p = 0; p < NP; p++) begin
            s1_kb_in[NP*c+p] = in_k[c] * in_b[NP*c+p];
         end
      end
   end

   always_comb begin
      s2_ksq_in = K2W'(s1_sq_ff[0]) + K2W'(s1_sq_ff[1]) + K2W'(s1_sq_ff[2]);
      for (int p = 0; p < NP; p++) begin
         s2_dot_in[p] = DOTW'(s1_kb_ff[p]) + DOTW'(s1_kb_ff[NP+p])
                      + DOTW'(s1_kb_ff[2*NP+p]);
      end
   end

   always_comb begin
      for (int c = 0; c < NK; c++) begin
         for (int p = 0; p < NP; p++) begin
            s3_num_in[NP*c+p] = s2_k_ff[c] * s2_dot_ff[p];
         end
      end
   end

   always_comb begin
      logic [NUMW-1:0] mag;
      div_in[0].ksq  = s3_ksq_ff;
      div_in[0].zero = (s3_ksq_ff == '0);
      div_in[0].quo  = '0;
      for (int l = 0; l < NL; l++) begin
         div_in[0].b[l]   = s3_b_ff[l];
         div_in[0].neg[l] = s3_num_ff[l][NUMW-1];
         mag              = s3_num_ff[l][NUMW-1] ? -s3_num_ff[l] : s3_num_ff[l];
         div_in[0].rem[l] = RW'(mag);
      end
   end

   // quotient bit QW-j is decided in stage j
   for (genvar j = 1; j <= QW; j++) begin : g_div
      always_comb begin
         logic [RW-1:0] dsh;
         dsh       = RW'(div_ff[j-1].ksq) << (QW - j);
         div_in[j] = div_ff[j-1];
         for (int l = 0; l < NL; l++) begin
            if (div_ff[j-1].rem[l] >= dsh) begin
               div_in[j].rem[l] = div_ff[j-1].rem[l] - dsh;
               div_in[j].quo[l] = {div_ff[j-1].quo[l][QW-2:0], 1'b1};
            end else begin
               div_in[j].quo[l] = {div_ff[j-1].quo[l][QW-2:0], 1'b0};
            end
         end
      end
   end

   // b - sign*q, clamped to the field range; zero k clears the cell
   always_comb begin
      logic [SW-1:0] bx;
      logic [SW-1:0] qx;
      logic [SW-1:0] sum;
      for (int l = 0; l < NL; l++) begin
         bx  = SW'($signed(div_ff[QW].b[l]));
         qx  = SW'(div_ff[QW].quo[l]);
         sum = div_ff[QW].neg[l] ? bx + qx : bx - qx;
         if (div_ff[QW].zero) begin
            rsp_p_in[l] = '0;
         end else if (sum[SW-1:BW-1] != {(SW-BW+1){sum[SW-1]}}) begin
            rsp_p_in[l] = sum[SW-1] ? {1'b1, {(BW-1){1'b0}}} : {1'b0, {(BW-1){1'b1}}};
         end else begin
            rsp_p_in[l] = sum[BW-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         dv_valid_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         s1_valid_ff  <= req_valid;
         s2_valid_ff  <= s1_valid_ff;
         s3_valid_ff  <= s2_valid_ff;
         dv_valid_ff  <= {dv_valid_ff[QW-1:0], s3_valid_ff};
         rsp_valid_ff <= dv_valid_ff[QW];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_b_ff   <= in_b;
         s1_k_ff   <= in_k;
         s1_sq_ff  <= s1_sq_in;
         s1_kb_ff  <= s1_kb_in;
         s2_b_ff   <= s1_b_ff;
         s2_k_ff   <= s1_k_ff;
         s2_ksq_ff <= s2_ksq_in;
         s2_dot_ff <= s2_dot_in;
         s3_b_ff   <= s2_b_ff;
         s3_ksq_ff <= s2_ksq_ff;
         s3_num_ff <= s3_num_in;
         for (int j = 0; j <= QW; j++) begin
            div_ff[j] <= div_in[j];
         end
         rsp_p_ff  <= rsp_p_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_px_real = rsp_p_ff[0];
   assign rsp_px_imag = rsp_p_ff[1];
   assign rsp_py_real = rsp_p_ff[2];
   assign rsp_py_imag = rsp_p_ff[3];
   assign rsp_pz_real = rsp_p_ff[4];
   assign rsp_pz_imag = rsp_p_ff[5];

endmodule
